[src/pltd_pkg.sv]
package pltd_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DELTA,
        S_JITTER,
        S_MUL,
        S_DIVCHK,
        S_DIV,
        S_DIV_END,
        S_WRITE,
        S_OUT
    } state_t;

    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_FAIL    = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam logic [2:0] STAT_VALID    = 3'd0;
    localparam logic [2:0] STAT_FAILED   = 3'd1;
    localparam logic [2:0] STAT_WARMUP   = 3'd2;
    localparam logic [2:0] STAT_IDENTITY = 3'd3;
    localparam logic [2:0] STAT_COUNTER  = 3'd4;
    localparam logic [2:0] STAT_FULL     = 3'd5;

    localparam logic CFG_CPU_COUNT = 1'b0;
    localparam logic CFG_PERIOD    = 1'b1;

    // stored entry: pid, tid, start, time, exec, wait from the lowest bit up
    localparam int ENTRY_W = 300;
    // divider datapath width, holds the divisor shifted by sixteen
    localparam int DIV_W = 92;

endpackage

[src/per_task_load_delta_tracker.sv]
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tuser action, s_tdata task sample
// m_      | out | m_tvalid/m_tready | m_tuser status, m_tdata deltas and ratios
// cfg_    | in  | cfg_wr_en         | cfg_addr register index, cfg_wdata value
// a sample scans every table entry through the ram read port; a valid one then runs
// the two 16-step ratio divisions in the shared divider, each skipped when it saturates;
// clear and unknown actions are handled in S_IDLE and send no result
// reset empties the table at once through the used bits
// while m_ holds a result the next request is processed; it stalls only at the end
module per_task_load_delta_tracker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [303:0]  s_tdata,   // pid, tid, start_ticks, sample_time_ns,
                                     // exec_total_ns, wait_total_ns, zero pad
    input  logic [1:0]    s_tuser,   // action
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [399:0]  m_tdata,   // out_pid, out_tid, out_time_ns, wall delta,
                                     // exec delta, wait delta, jitter,
                                     // load_pct_q8, wait_pct_q8, zero pad
    output logic [2:0]    m_tuser,   // status
    input  logic          cfg_wr_en,
    input  logic          cfg_addr,
    input  logic [63:0]   cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = pltd_pkg::DIV_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);

    pltd_pkg::state_t state_reg, state_next;

    logic [10:0]            cpu_count_reg, cpu_count_next;
    logic [63:0]            period_reg, period_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          sel_reg, sel_next;
    logic [3:0]    cnt_reg, cnt_next;

    // payload
    logic [1:0]    act_reg, act_next;
    logic [21:0]   pid_reg, pid_next, tid_reg, tid_next;
    logic [63:0]   start_reg, start_next, time_reg, time_next;
    logic [63:0]   exec_reg, exec_next, wait_reg, wait_next;
    logic [63:0]   p_start_reg, p_start_next, p_time_reg, p_time_next;
    logic [63:0]   p_exec_reg, p_exec_next, p_wait_reg, p_wait_next;
    logic [2:0]    status_reg, status_next;
    logic [63:0]   wall_reg, wall_next, de_reg, de_next, dw_reg, dw_next;
    logic [63:0]   jit_reg, jit_next;
    logic [15:0]   load_reg, load_next, waitp_reg, waitp_next, q_reg, q_next;
    logic [DW-1:0] num_reg, num_next, den_reg, den_next;
    logic [399:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]    m_tuser_reg, m_tuser_next;

    logic [pltd_pkg::ENTRY_W-1:0] rd_data;
    logic [pltd_pkg::ENTRY_W-1:0] wr_data;
    logic                         ram_we;

    logic [21:0] rd_pid, rd_tid;
    logic        accept;
    logic        out_free;
    logic        prev_bad;
    logic [10:0] cpus;
    logic [63:0] ratio_num;
    logic [74:0] ratio_den;
    logic [DW-1:0] den_sat;
    logic        div_ge;

    assign rd_pid   = rd_data[21:0];
    assign rd_tid   = rd_data[43:22];
    assign wr_data  = {wait_reg, exec_reg, time_reg, start_reg, tid_reg, pid_reg};
    assign ram_we   = (state_reg == pltd_pkg::S_WRITE);
    assign s_tready = (state_reg == pltd_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign prev_bad = (time_reg <= p_time_reg) || (exec_reg < p_exec_reg) ||
                      (wait_reg < p_wait_reg);
    assign cpus     = (cpu_count_reg == 11'd0) ? 11'd1 : cpu_count_reg;
    assign ratio_num = sel_reg ? dw_reg : de_reg;
    assign ratio_den = sel_reg ? {11'd0, wall_reg} : ({11'd0, wall_reg} * {64'd0, cpus});
    assign den_sat  = {den_reg[DW-17:0], 16'd0};
    assign div_ge   = (num_reg >= den_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    pltd_ram #(
        .WIDTH(pltd_pkg::ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(slot_reg),
        .wr_data(wr_data),
        .rd_addr(scan_idx_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pltd_pkg::S_IDLE: begin
                if (accept && (s_tuser == pltd_pkg::ACT_SAMPLE ||
                               s_tuser == pltd_pkg::ACT_FAIL)) begin
                    state_next = pltd_pkg::S_SCAN;
                end
            end
            pltd_pkg::S_SCAN: begin
                if (chk_valid_reg && chk_idx_reg == LAST_IDX) begin
                    state_next = pltd_pkg::S_DECIDE;
                end
            end
            pltd_pkg::S_DECIDE: begin
                if (act_reg == pltd_pkg::ACT_FAIL) begin
                    state_next = pltd_pkg::S_OUT;
                end else if (!hit_reg) begin
                    state_next = free_reg ? pltd_pkg::S_WRITE : pltd_pkg::S_OUT;
                end else if (start_reg != p_start_reg || prev_bad) begin
                    state_next = pltd_pkg::S_WRITE;
                end else begin
                    state_next = pltd_pkg::S_DELTA;
                end
            end
            pltd_pkg::S_DELTA:  state_next = pltd_pkg::S_JITTER;
            pltd_pkg::S_JITTER: state_next = pltd_pkg::S_MUL;
            pltd_pkg::S_MUL:    state_next = pltd_pkg::S_DIVCHK;
            pltd_pkg::S_DIVCHK: begin
                state_next = (num_reg >= den_sat) ? pltd_pkg::S_DIV_END : pltd_pkg::S_DIV;
            end
            pltd_pkg::S_DIV: begin
                if (cnt_reg == 4'd0) begin
                    state_next = pltd_pkg::S_DIV_END;
                end
            end
            pltd_pkg::S_DIV_END: begin
                state_next = sel_reg ? pltd_pkg::S_WRITE : pltd_pkg::S_MUL;
            end
            pltd_pkg::S_WRITE: state_next = pltd_pkg::S_OUT;
            pltd_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = pltd_pkg::S_IDLE;
                end
            end
            default: state_next = pltd_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cpu_count_next = cpu_count_reg;
        period_next    = period_reg;
        used_next      = used_reg;
        m_tvalid_next  = m_tvalid_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        slot_next      = slot_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        act_next       = act_reg;
        pid_next       = pid_reg;
        tid_next       = tid_reg;
        start_next     = start_reg;
        time_next      = time_reg;
        exec_next      = exec_reg;
        wait_next      = wait_reg;
        p_start_next   = p_start_reg;
        p_time_next    = p_time_reg;
        p_exec_next    = p_exec_reg;
        p_wait_next    = p_wait_reg;
        status_next    = status_reg;
        wall_next      = wall_reg;
        de_next        = de_reg;
        dw_next        = dw_reg;
        jit_next       = jit_reg;
        load_next      = load_reg;
        waitp_next     = waitp_reg;
        q_next         = q_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            if (cfg_addr == pltd_pkg::CFG_CPU_COUNT) begin
                cpu_count_next = cfg_wdata[10:0];
            end else begin
                period_next = cfg_wdata;
            end
        end

        case (state_reg)
            pltd_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_tuser == pltd_pkg::ACT_CLEAR) begin
                        used_next = '0;
                    end
                    act_next      = s_tuser;
                    pid_next      = s_tdata[21:0];
                    tid_next      = s_tdata[43:22];
                    start_next    = s_tdata[107:44];
                    time_next     = s_tdata[171:108];
                    exec_next     = s_tdata[235:172];
                    wait_next     = s_tdata[299:236];
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    wall_next     = '0;
                    de_next       = '0;
                    dw_next       = '0;
                    jit_next      = '0;
                    load_next     = '0;
                    waitp_next    = '0;
                    sel_next      = 1'b0;
                end
            end
            pltd_pkg::S_SCAN: begin
                // read issued for scan_idx, compare the entry whose read was issued the cycle before
                if (scan_idx_reg < DEPTH_C) begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[AW-1:0];
                end
                if (chk_valid_reg) begin
                    if (used_reg[chk_idx_reg]) begin
                        if (!hit_reg && rd_pid == pid_reg && rd_tid == tid_reg) begin
                            hit_next     = 1'b1;
                            hit_idx_next = chk_idx_reg;
                            p_start_next = rd_data[107:44];
                            p_time_next  = rd_data[171:108];
                            p_exec_next  = rd_data[235:172];
                            p_wait_next  = rd_data[299:236];
                        end
                    end else if (!free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
            end
            pltd_pkg::S_DECIDE: begin
                slot_next = hit_reg ? hit_idx_reg : free_idx_reg;
                if (act_reg == pltd_pkg::ACT_FAIL) begin
                    status_next = pltd_pkg::STAT_FAILED;
                    if (hit_reg) begin
                        used_next[hit_idx_reg] = 1'b0;
                    end
                end else if (!hit_reg) begin
                    status_next = free_reg ? pltd_pkg::STAT_WARMUP : pltd_pkg::STAT_FULL;
                end else if (start_reg != p_start_reg) begin
                    status_next = pltd_pkg::STAT_IDENTITY;
                end else if (prev_bad) begin
                    status_next = pltd_pkg::STAT_COUNTER;
                end else begin
                    status_next = pltd_pkg::STAT_VALID;
                end
            end
            pltd_pkg::S_DELTA: begin
                wall_next = time_reg - p_time_reg;
                de_next   = exec_reg - p_exec_reg;
                dw_next   = wait_reg - p_wait_reg;
            end
            pltd_pkg::S_JITTER: begin
                if (period_reg == 64'd0) begin
                    jit_next = '0;
                end else if (wall_reg > period_reg) begin
                    jit_next = wall_reg - period_reg;
                end else begin
                    jit_next = period_reg - wall_reg;
                end
            end
            pltd_pkg::S_MUL: begin
                // 25600 = 2^14 + 2^13 + 2^10
                num_next = {14'd0, ratio_num, 14'd0} + {15'd0, ratio_num, 13'd0} +
                           {18'd0, ratio_num, 10'd0};
                den_next = {17'd0, ratio_den};
            end
            pltd_pkg::S_DIVCHK: begin
                if (num_reg >= den_sat) begin
                    q_next = 16'hFFFF;
                end else begin
                    q_next   = '0;
                    cnt_next = 4'd15;
                    den_next = {den_reg[DW-16:0], 15'd0};
                end
            end
            pltd_pkg::S_DIV: begin
                if (div_ge) begin
                    num_next = num_reg - den_reg;
                end
                q_next   = {q_reg[14:0], div_ge};
                den_next = den_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
            end
            pltd_pkg::S_DIV_END: begin
                if (sel_reg) begin
                    waitp_next = q_reg;
                end else begin
                    load_next = q_reg;
                    sel_next  = 1'b1;
                end
            end
            pltd_pkg::S_WRITE: begin
                used_next[slot_reg] = 1'b1;
            end
            pltd_pkg::S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {4'd0, waitp_reg, load_reg, jit_reg, dw_reg, de_reg,
                                     wall_reg, time_reg, tid_reg, pid_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pltd_pkg::S_IDLE;
            cpu_count_reg <= 11'd1;
            period_reg    <= '0;
            used_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cpu_count_reg <= cpu_count_next;
            period_reg    <= period_next;
            used_reg      <= used_next;
            m_tvalid_reg  <= m_tvalid_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        slot_reg     <= slot_next;
        sel_reg      <= sel_next;
        cnt_reg      <= cnt_next;
        act_reg      <= act_next;
        pid_reg      <= pid_next;
        tid_reg      <= tid_next;
        start_reg    <= start_next;
        time_reg     <= time_next;
        exec_reg     <= exec_next;
        wait_reg     <= wait_next;
        p_start_reg  <= p_start_next;
        p_time_reg   <= p_time_next;
        p_exec_reg   <= p_exec_next;
        p_wait_reg   <= p_wait_next;
        status_reg   <= status_next;
        wall_reg     <= wall_next;
        de_reg       <= de_next;
        dw_reg       <= dw_next;
        jit_reg      <= jit_next;
        load_reg     <= load_next;
        waitp_reg    <= waitp_next;
        q_reg        <= q_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // a non-valid status carries zero deltas, jitter and ratios
    a_zero_unless_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != pltd_pkg::STAT_VALID) |-> (m_tdata[395:108] == '0))
        else $error("nonzero delta on non-valid status");

    // a table write marks its slot used
    a_write_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pltd_pkg::S_WRITE) |=> used_reg[$past(slot_reg)])
        else $error("written slot not marked used");

    // the divider runs only on a valid sample
    a_div_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pltd_pkg::S_DIV) |-> (hit_reg && status_reg == pltd_pkg::STAT_VALID))
        else $error("divider active without a valid sample");

endmodule

[src/pltd_ram.sv]
module pltd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
